>>> hdl/llfr_pkg.sv
// Shared constants, codes and types of the LED link frame receiver.
// Used by every module of the block; no dependencies.
`default_nettype none

package llfr_pkg;

  localparam int BUF_BYTES = 64;
  localparam int POS_W     = $clog2(BUF_BYTES);
  localparam int BANKS     = 2;
  localparam int RAM_DEPTH = BANKS * BUF_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int CNT_W     = 6;
  localparam int APB_AW    = 4;

  localparam logic [POS_W-1:0] POS_FIRST    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(2);
  localparam logic [POS_W-1:0] POS_MODE     = POS_W'(3);
  localparam logic [POS_W-1:0] POS_RED      = POS_W'(4);
  localparam logic [POS_W-1:0] POS_GREEN    = POS_W'(5);
  localparam logic [POS_W-1:0] POS_BLUE     = POS_W'(6);
  localparam logic [POS_W-1:0] POS_PERIOD   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_VER_BASE = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(BUF_BYTES - 1);

  localparam logic [7:0] VER_OVERHEAD = 8'd5;

  localparam logic [1:0] REG_HEADER   = 2'd0;
  localparam logic [1:0] REG_FOOTER   = 2'd1;
  localparam logic [1:0] REG_LED_TYPE = 2'd2;
  localparam logic [1:0] REG_VER_TYPE = 2'd3;

  localparam logic KIND_LED     = 1'b0;
  localparam logic KIND_VERSION = 1'b1;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] footer;
    logic [7:0] led_type;
    logic [7:0] ver_type;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic             bank;
    logic [CNT_W-1:0] count;
    logic [7:0]       mode;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       period;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/llfr_ifs.sv
// Valid/ready channel interfaces of the LED link frame receiver:
// the received byte stream and the report stream. No dependencies.
`default_nettype none

interface llfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface llfr_report_if;
  logic       valid;
  logic       ready;
  logic       frame_kind;
  logic [7:0] effect_mode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] effect_period;
  logic [7:0] version_byte;
  logic [5:0] version_index;
  logic [5:0] version_count;
  logic       last;

  modport source (
    output valid, input ready,
    output frame_kind, output effect_mode, output red, output green, output blue,
    output effect_period, output version_byte, output version_index,
    output version_count, output last
  );
  modport sink (
    input valid, output ready,
    input frame_kind, input effect_mode, input red, input green, input blue,
    input effect_period, input version_byte, input version_index,
    input version_count, input last
  );
endinterface

`default_nettype wire

>>> hdl/llfr_frame_ram.sv
// Two-bank frame byte store: one write port, one read port with registered data.
// Depends on llfr_pkg.
`default_nettype none

module llfr_frame_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [llfr_pkg::RAM_AW-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic                      re,
  input  logic [llfr_pkg::RAM_AW-1:0] raddr,
  output logic [7:0]                rdata
);
  import llfr_pkg::*;

  logic [7:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/llfr_cmd_fifo.sv
// Two-entry request queue between the frame parser and the report sequencer.
// Depends on llfr_pkg.
`default_nettype none

module llfr_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  llfr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output llfr_pkg::cmd_t head
);
  import llfr_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = fill == 2'd2;
  assign nonempty = fill != 2'd0;
  assign head     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> hdl/llfr_front.sv
// Frame parser: accepts received bytes, stores them, checks footer and sum,
// classifies the frame and queues one report request for a good LED or version frame. Depends on llfr_pkg.
`default_nettype none

module llfr_front (
  input  logic                        clk,
  input  logic                        rst,
  llfr_byte_if.sink                   link,
  input  llfr_pkg::cfg_t              cfg,
  input  logic                        fifo_full,
  output logic                        push,
  output llfr_pkg::cmd_t              push_cmd,
  input  logic                        release_bank,
  output logic                        ram_we,
  output logic [llfr_pkg::RAM_AW-1:0] ram_waddr,
  output logic [7:0]                  ram_wdata
);
  import llfr_pkg::*;

  logic             in_frame;
  logic [POS_W-1:0] pos;
  logic [7:0]       frame_length;
  logic [7:0]       running_sum;
  logic [7:0]       prev_byte;
  logic [7:0]       type_byte;
  logic [7:0]       mode_byte;
  logic [7:0]       red_byte;
  logic [7:0]       green_byte;
  logic [7:0]       blue_byte;
  logic [7:0]       period_byte;
  logic             bank;
  logic [1:0]       outstanding;

  logic             accept;
  logic [7:0]       b;
  logic [7:0]       len_now;
  logic [7:0]       type_now;
  logic             closing;
  logic             good;
  logic             is_led;
  logic             is_ver;
  logic [CNT_W-1:0] count;
  logic             take_bank;

  assign link.ready = !fifo_full && (outstanding != 2'd2);
  assign accept     = link.valid && link.ready;
  assign b          = link.rx_byte;

  always_comb begin
    len_now  = (pos == POS_FIRST) ? b : frame_length;
    type_now = (pos == POS_TYPE) ? b : type_byte;
    closing  = in_frame && (len_now != 8'd0) && (8'(pos) == len_now - 8'd1);
    good     = accept && closing && (b == cfg.footer)
               && ((running_sum - prev_byte) == prev_byte);
    is_led   = type_now == cfg.led_type;
    is_ver   = !is_led && (type_now == cfg.ver_type);
    count    = (len_now > VER_OVERHEAD) ? CNT_W'(len_now - VER_OVERHEAD) : '0;
    push     = good && (is_led || is_ver);
    take_bank = push && is_ver && (count != '0);

    push_cmd.kind   = is_led ? KIND_LED : KIND_VERSION;
    push_cmd.bank   = bank;
    push_cmd.count  = is_led ? '0 : count;
    push_cmd.mode   = (pos == POS_MODE) ? b : mode_byte;
    push_cmd.red    = (pos == POS_RED) ? b : red_byte;
    push_cmd.green  = (pos == POS_GREEN) ? b : green_byte;
    push_cmd.blue   = (pos == POS_BLUE) ? b : blue_byte;
    push_cmd.period = (pos == POS_PERIOD) ? b : period_byte;

    ram_we    = accept && (in_frame || (b == cfg.header));
    ram_waddr = {bank, (in_frame ? pos : '0)};
    ram_wdata = b;
  end

  // stored copies of the fixed-position bytes
  always_ff @(posedge clk) begin
    if (accept && in_frame) begin
      if (pos == POS_TYPE) begin
        type_byte <= b;
      end
      if (pos == POS_MODE) begin
        mode_byte <= b;
      end
      if (pos == POS_RED) begin
        red_byte <= b;
      end
      if (pos == POS_GREEN) begin
        green_byte <= b;
      end
      if (pos == POS_BLUE) begin
        blue_byte <= b;
      end
      if (pos == POS_PERIOD) begin
        period_byte <= b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      pos          <= '0;
      frame_length <= 8'd0;
      running_sum  <= 8'd0;
      prev_byte    <= 8'd0;
      bank         <= 1'b0;
      outstanding  <= 2'd0;
    end else begin
      if (accept) begin
        if (!in_frame) begin
          if (b == cfg.header) begin
            in_frame    <= 1'b1;
            pos         <= POS_FIRST;
            running_sum <= b;
            prev_byte   <= b;
          end
        end else begin
          if (pos == POS_FIRST) begin
            frame_length <= b;
          end
          if (closing) begin
            in_frame    <= 1'b0;
            pos         <= '0;
            running_sum <= 8'd0;
          end else begin
            running_sum <= running_sum + b;
            prev_byte   <= b;
            if (pos == POS_LAST) begin
              in_frame    <= 1'b0;
              pos         <= '0;
              running_sum <= 8'd0;
            end else begin
              pos <= pos + POS_W'(1);
            end
          end
        end
      end
      if (take_bank) begin
        bank <= ~bank;
      end
      outstanding <= outstanding + {1'b0, take_bank} - {1'b0, release_bank};
    end
  end

endmodule

`default_nettype wire

>>> hdl/llfr_back.sv
// Report sequencer: takes queued requests and drives the report channel,
// reading version characters from the frame store. Depends on llfr_pkg.
`default_nettype none

module llfr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_nonempty,
  input  llfr_pkg::cmd_t              q_head,
  output logic                        pop,
  output logic                        ram_re,
  output logic [llfr_pkg::RAM_AW-1:0] ram_raddr,
  input  logic [7:0]                  ram_rdata,
  output logic                        release_bank,
  llfr_report_if.source               report
);
  import llfr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  cmd_t             cur;
  logic [CNT_W-1:0] k;
  logic             k_last;
  logic             slot_free;

  logic             out_valid;
  logic             out_kind;
  logic [7:0]       out_mode;
  logic [7:0]       out_red;
  logic [7:0]       out_green;
  logic [7:0]       out_blue;
  logic [7:0]       out_period;
  logic [7:0]       out_vbyte;
  logic [5:0]       out_vindex;
  logic [5:0]       out_vcount;
  logic             out_last;

  assign report.valid         = out_valid;
  assign report.frame_kind    = out_kind;
  assign report.effect_mode   = out_mode;
  assign report.red           = out_red;
  assign report.green         = out_green;
  assign report.blue          = out_blue;
  assign report.effect_period = out_period;
  assign report.version_byte  = out_vbyte;
  assign report.version_index = out_vindex;
  assign report.version_count = out_vcount;
  assign report.last          = out_last;

  assign slot_free = !out_valid || report.ready;
  assign k_last    = (k + CNT_W'(1)) == cur.count;

  always_comb begin
    pop          = 1'b0;
    ram_re       = 1'b0;
    release_bank = 1'b0;
    ram_raddr    = {cur.bank, POS_VER_BASE + POS_W'(k)};
    state_next   = state;
    case (state)
      ST_IDLE: begin
        if (q_nonempty && slot_free) begin
          pop = 1'b1;
          if ((q_head.kind == KIND_VERSION) && (q_head.count != '0)) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_re     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          if (k_last) begin
            release_bank = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && ((q_head.kind == KIND_LED) || (q_head.count == '0))) begin
        out_valid <= 1'b1;
      end else if ((state == ST_LOAD) && slot_free) begin
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
      k   <= '0;
      out_kind   <= q_head.kind;
      out_mode   <= (q_head.kind == KIND_LED) ? q_head.mode : 8'd0;
      out_red    <= (q_head.kind == KIND_LED) ? q_head.red : 8'd0;
      out_green  <= (q_head.kind == KIND_LED) ? q_head.green : 8'd0;
      out_blue   <= (q_head.kind == KIND_LED) ? q_head.blue : 8'd0;
      out_period <= (q_head.kind == KIND_LED) ? q_head.period : 8'd0;
      out_vbyte  <= 8'd0;
      out_vindex <= 6'd0;
      out_vcount <= 6'd0;
      out_last   <= 1'b1;
    end else if ((state == ST_LOAD) && slot_free) begin
      out_kind   <= KIND_VERSION;
      out_mode   <= 8'd0;
      out_red    <= 8'd0;
      out_green  <= 8'd0;
      out_blue   <= 8'd0;
      out_period <= 8'd0;
      out_vbyte  <= ram_rdata;
      out_vindex <= 6'(k);
      out_vcount <= 6'(cur.count);
      out_last   <= k_last;
      k          <= k + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> hdl/led_link_frame_receiver.sv
// LED link frame receiver, top level: register port, frame parser, request queue,
// two-bank frame store and report sequencer.
// Depends on llfr_pkg, llfr_ifs, llfr_frame_ram, llfr_cmd_fifo, llfr_front, llfr_back.
//
// Usage:
//   link   : received bytes, one per accepted valid/ready request.
//   report : report items; an LED frame gives one item, a version frame a run of
//            characters with last on the final one (an empty run gives one item).
//   APB    : header, footer, LED type and version type registers at 0x0..0xC.
// An LED report or empty version report passes the request queue and then the
// report output register after the footer byte is accepted. Version characters
// leave one at a time, set by the store's single read port (read, then load).
// Throughput: one byte per cycle. The parser stalls the link only when the
// request queue is full or two version runs are still unread, since each run
// holds one of the two store banks until its last character is loaded.
// Reset: parser waits for a header, queue empties, no report is valid, the
// registers take their default codes. The store needs no clearing.
// A stalled report holds its item; the parser takes bytes until it stalls the link.
`default_nettype none

module led_link_frame_receiver (
  input  logic                        clk,
  input  logic                        rst,
  llfr_byte_if.sink                   link,
  llfr_report_if.source               report,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [llfr_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import llfr_pkg::*;

  cfg_t              cfg;
  logic              cfg_we;
  logic              push;
  cmd_t              push_cmd;
  logic              fifo_full;
  logic              pop;
  logic              q_nonempty;
  cmd_t              q_head;
  logic              release_bank;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header   <= 8'd90;
      cfg.footer   <= 8'd165;
      cfg.led_type <= 8'd1;
      cfg.ver_type <= 8'd2;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_HEADER:   cfg.header   <= pwdata[7:0];
        REG_FOOTER:   cfg.footer   <= pwdata[7:0];
        REG_LED_TYPE: cfg.led_type <= pwdata[7:0];
        REG_VER_TYPE: cfg.ver_type <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HEADER:   prdata = {24'd0, cfg.header};
      REG_FOOTER:   prdata = {24'd0, cfg.footer};
      REG_LED_TYPE: prdata = {24'd0, cfg.led_type};
      REG_VER_TYPE: prdata = {24'd0, cfg.ver_type};
      default:      prdata = 32'd0;
    endcase
  end

  llfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .link         (link),
    .cfg          (cfg),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_cmd     (push_cmd),
    .release_bank (release_bank),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata)
  );

  llfr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  llfr_frame_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  llfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .q_head       (q_head),
    .pop          (pop),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .release_bank (release_bank),
    .report       (report)
  );

endmodule

`default_nettype wire
